// ===== rtl/core/rrts_pkg.sv =====
// Shared types and constants for the round-robin tick scheduler.
// No dependencies; every other file in rtl/core uses this package.
package rrts_pkg;

    localparam int ID_W   = 16;
    localparam int TIME_W = 16;

    // request mode codes
    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LINK_NEW,
        S_LINK_PREV,
        S_FETCH,
        S_EVAL,
        S_OUT
    } t_state;

    // write enables into the task table
    typedef struct packed {
        logic task_we;
        logic next_we;
    } t_tbl_wen;

endpackage

// ===== rtl/core/rrts_if.sv =====
// Valid/ready channel interfaces for scheduler requests and results.
// Depends on rrts_pkg for field widths.
interface rrts_req_if;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [rrts_pkg::ID_W-1:0]   process_id;
    logic [rrts_pkg::TIME_W-1:0] exec_time;

    modport source (output valid, output mode, output process_id, output exec_time,
                    input ready);
    modport sink   (input valid, input mode, input process_id, input exec_time,
                    output ready);
endinterface

interface rrts_rsp_if #(
    parameter int CNT_W = 5
);
    logic                    valid;
    logic                    ready;
    logic                    done_valid;
    logic [rrts_pkg::ID_W-1:0] done_id;
    logic                    add_rejected;
    logic [CNT_W-1:0]        live_tasks;

    modport source (output valid, output done_valid, output done_id,
                    output add_rejected, output live_tasks, input ready);
    modport sink   (input valid, input done_valid, input done_id,
                    input add_rejected, input live_tasks, output ready);
endinterface

// ===== rtl/core/rrts_slot_scan.sv =====
// Free-slot finder: steps through the in-use vector one slot per cycle.
// Depends on rrts_pkg.
module rrts_slot_scan #(
    parameter int DEPTH = 16,
    parameter int SW    = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DEPTH-1:0] i_in_use,
    output logic             o_found,
    output logic [SW-1:0]    o_slot
);
    import rrts_pkg::*;

    logic          r_busy;
    logic [SW-1:0] r_idx;

    // a free slot always exists when a scan is started
    assign o_found = r_busy && !i_in_use[r_idx];
    assign o_slot  = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy) begin
            if (!i_in_use[r_idx]) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + SW'(1);
            end
        end
    end

endmodule

// ===== rtl/core/rrts_table.sv =====
// Task table: id, ticks left and ring link per slot, one write address,
// one registered read address. Depends on rrts_pkg.
module rrts_table #(
    parameter int DEPTH = 16,
    parameter int SW    = 4
) (
    input  logic                         i_clk,
    input  rrts_pkg::t_tbl_wen           i_wen,
    input  logic [SW-1:0]                i_wr_addr,
    input  logic [rrts_pkg::ID_W-1:0]    i_wr_id,
    input  logic [rrts_pkg::TIME_W-1:0]  i_wr_ticks,
    input  logic [SW-1:0]                i_wr_next,
    input  logic [SW-1:0]                i_rd_addr,
    output logic [rrts_pkg::ID_W-1:0]    o_rd_id,
    output logic [rrts_pkg::TIME_W-1:0]  o_rd_ticks,
    output logic [SW-1:0]                o_rd_next
);
    import rrts_pkg::*;

    logic [ID_W-1:0]   mem_id    [DEPTH];
    logic [TIME_W-1:0] mem_ticks [DEPTH];
    logic [SW-1:0]     mem_next  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wen.task_we) begin
            mem_id[i_wr_addr]    <= i_wr_id;
            mem_ticks[i_wr_addr] <= i_wr_ticks;
        end
        if (i_wen.next_we) begin
            mem_next[i_wr_addr] <= i_wr_next;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_id    <= mem_id[i_rd_addr];
        o_rd_ticks <= mem_ticks[i_rd_addr];
        o_rd_next  <= mem_next[i_rd_addr];
    end

endmodule

// ===== rtl/core/round_robin_tick_scheduler.sv =====
// Round-robin scheduler with a one-tick quantum: top level and sequencer.
// Depends on rrts_pkg, rrts_if, rrts_slot_scan and rrts_table.
//
// Usage: requests arrive on i_req (valid/ready). mode MODE_ADD places
// process_id with exec_time ticks last in the rotation; mode MODE_TICK takes
// one tick off the serving task and moves service on. Each request yields
// exactly one result on o_rsp: done_valid/done_id when a task finished,
// add_rejected when the table was full, and live_tasks after the request.
// A tick reads the table, updates the serving task and loads the result; a
// tick on an empty ring or a rejected add goes straight to the result load.
// An add first has the slot scanner find the lowest free slot, checking one
// slot per cycle, then S_LINK_NEW and S_LINK_PREV write the task entry and
// the ring links. One request is in work at a time; i_req.ready is high only
// while the sequencer is idle. The result register lets the next request be
// accepted while the previous result waits; if the receiver stalls, the
// sequencer holds its finished result until the register frees.
// Reset clears the slot-in-use bits, pointers, count and result valid flag;
// table contents stay undefined and are only read for slots in use.
module round_robin_tick_scheduler #(
    parameter int MAX_TASKS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrts_req_if.sink    i_req,
    rrts_rsp_if.source  o_rsp
);
    import rrts_pkg::*;

    localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_TASKS);

    t_state r_state;
    t_state n_state;

    logic                 r_mode;
    logic [ID_W-1:0]      r_id;
    logic [TIME_W-1:0]    r_time;
    logic [MAX_TASKS-1:0] r_in_use;
    logic [SW-1:0]        r_serving;
    logic [SW-1:0]        r_before;
    logic [CW-1:0]        r_count;
    logic [SW-1:0]        r_free;
    logic                 r_done;
    logic [ID_W-1:0]      r_done_id;
    logic                 r_rej;

    logic                 r_out_valid;
    logic                 r_out_done;
    logic [ID_W-1:0]      r_out_id;
    logic                 r_out_rej;
    logic [CW-1:0]        r_out_cnt;

    logic                 accept;
    logic                 out_free;
    logic                 scan_start;
    logic                 scan_found;
    logic [SW-1:0]        scan_slot;
    logic                 last_tick;

    t_tbl_wen             tbl_wen;
    logic [SW-1:0]        wr_addr;
    logic [ID_W-1:0]      wr_id;
    logic [TIME_W-1:0]    wr_ticks;
    logic [SW-1:0]        wr_next;
    logic [ID_W-1:0]      rd_id;
    logic [TIME_W-1:0]    rd_ticks;
    logic [SW-1:0]        rd_next;

    assign accept    = i_req.valid && i_req.ready;
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign last_tick = (rd_ticks <= TIME_W'(1));

    rrts_slot_scan #(.DEPTH(MAX_TASKS), .SW(SW)) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (scan_start),
        .i_in_use (r_in_use),
        .o_found  (scan_found),
        .o_slot   (scan_slot)
    );

    rrts_table #(.DEPTH(MAX_TASKS), .SW(SW)) u_table (
        .i_clk      (i_clk),
        .i_wen      (tbl_wen),
        .i_wr_addr  (wr_addr),
        .i_wr_id    (wr_id),
        .i_wr_ticks (wr_ticks),
        .i_wr_next  (wr_next),
        .i_rd_addr  (r_serving),
        .o_rd_id    (rd_id),
        .o_rd_ticks (rd_ticks),
        .o_rd_next  (rd_next)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.mode == MODE_TICK) begin
                        n_state = (r_count == '0) ? S_OUT : S_FETCH;
                    end else begin
                        n_state = (r_count == FULL_CNT) ? S_OUT : S_SCAN;
                    end
                end
            end
            S_SCAN:      if (scan_found) n_state = S_LINK_NEW;
            S_LINK_NEW:  n_state = S_LINK_PREV;
            S_LINK_PREV: n_state = S_OUT;
            S_FETCH:     n_state = S_EVAL;
            S_EVAL:      n_state = S_OUT;
            S_OUT:       if (out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_req.ready = 1'b0;
        scan_start  = 1'b0;
        tbl_wen     = '0;
        wr_addr     = r_free;
        wr_id       = r_id;
        wr_ticks    = r_time;
        wr_next     = r_free;
        unique case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                scan_start  = i_req.valid && (i_req.mode == MODE_ADD) &&
                              (r_count != FULL_CNT);
            end
            S_LINK_NEW: begin
                tbl_wen.task_we = 1'b1;
                tbl_wen.next_we = 1'b1;
                wr_next         = (r_count == '0) ? r_free : r_serving;
            end
            S_LINK_PREV: begin
                // close the ring behind the new task
                tbl_wen.next_we = (r_count != '0);
                wr_addr         = r_before;
                wr_next         = r_free;
            end
            S_EVAL: begin
                if (last_tick) begin
                    // unlink the finished task
                    tbl_wen.next_we = (r_count != CW'(1));
                    wr_addr         = r_before;
                    wr_next         = rd_next;
                end else begin
                    tbl_wen.task_we = 1'b1;
                    wr_addr         = r_serving;
                    wr_id           = rd_id;
                    wr_ticks        = rd_ticks - TIME_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_in_use  <= '0;
            r_serving <= '0;
            r_before  <= '0;
            r_count   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_LINK_PREV: begin
                    r_in_use[r_free] <= 1'b1;
                    if (r_count == '0) begin
                        r_serving <= r_free;
                    end
                    r_before <= r_free;
                    r_count  <= r_count + CW'(1);
                end
                S_EVAL: begin
                    if (last_tick) begin
                        r_in_use[r_serving] <= 1'b0;
                        r_count             <= r_count - CW'(1);
                        if (r_count == CW'(1)) begin
                            r_serving <= '0;
                            r_before  <= '0;
                        end else begin
                            r_serving <= rd_next;
                        end
                    end else begin
                        r_before  <= r_serving;
                        r_serving <= rd_next;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // request capture and pending result
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && accept) begin
            r_mode    <= i_req.mode;
            r_id      <= i_req.process_id;
            r_time    <= i_req.exec_time;
            r_done    <= 1'b0;
            r_done_id <= '0;
            r_rej     <= (i_req.mode == MODE_ADD) && (r_count == FULL_CNT);
        end
        if (r_state == S_SCAN && scan_found) begin
            r_free <= scan_slot;
        end
        if (r_state == S_EVAL && last_tick) begin
            r_done    <= 1'b1;
            r_done_id <= rd_id;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            // tick results only carry done fields; add results only the reject flag
            r_out_done <= r_done && (r_mode == MODE_TICK);
            r_out_id   <= r_done_id;
            r_out_rej  <= r_rej;
            r_out_cnt  <= r_count;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.done_valid   = r_out_done;
    assign o_rsp.done_id      = r_out_id;
    assign o_rsp.add_rejected = r_out_rej;
    assign o_rsp.live_tasks   = r_out_cnt;

endmodule

// ===== dv/rrts_sched_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the round-robin tick scheduler: mirrors the task ring on
// every accepted request and compares each accepted result with the oldest one.
// Depends on rrts_pkg and the request/result interfaces in rrts_if.
module rrts_sched_checker #(
    parameter int MAX_TASKS = 16,
    parameter int CNT_W     = 5
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rrts_req_if  i_req,
    rrts_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    import rrts_pkg::*;

    localparam int SLOT_W     = $clog2(MAX_TASKS);
    localparam int SHOW_LIMIT = 10;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef struct packed {
        logic              done_valid;
        logic [ID_W-1:0]   done_id;
        logic              add_rejected;
        logic [CNT_W-1:0]  live_tasks;
    } sched_result_t;

    // mirror of the task ring
    logic [ID_W-1:0]      task_id_q [MAX_TASKS];
    logic [TIME_W-1:0]    ticks_q   [MAX_TASKS];
    slot_t                ring_q    [MAX_TASKS];
    logic [MAX_TASKS-1:0] busy_q;
    slot_t                serve_q;
    slot_t                prior_q;
    int                   live_q;

    sched_result_t        expected_q [$];
    int                   fails = 0;

    // Apply one request to the mirror and return the result it must produce.
    function automatic sched_result_t schedule_step(input logic m,
                                                    input logic [ID_W-1:0] pid,
                                                    input logic [TIME_W-1:0] et);
        sched_result_t r;
        int            free_slot;
        slot_t         cur;
        slot_t         nxt;
        r         = '0;
        free_slot = -1;
        if (m == MODE_ADD) begin
            for (int s = MAX_TASKS - 1; s >= 0; s--) begin
                if (!busy_q[s]) free_slot = s;
            end
            if (live_q >= MAX_TASKS || free_slot < 0) begin
                r.add_rejected = 1'b1;
            end else begin
                task_id_q[free_slot] = pid;
                ticks_q[free_slot]   = et;
                busy_q[free_slot]    = 1'b1;
                if (live_q == 0) begin
                    ring_q[free_slot] = slot_t'(free_slot);
                    serve_q           = slot_t'(free_slot);
                end else begin
                    // link in just before the serving task
                    ring_q[free_slot] = serve_q;
                    ring_q[prior_q]   = slot_t'(free_slot);
                end
                prior_q = slot_t'(free_slot);
                live_q++;
            end
        end else if (live_q != 0) begin
            cur = serve_q;
            nxt = ring_q[cur];
            if (ticks_q[cur] <= 1) begin
                r.done_valid = 1'b1;
                r.done_id    = task_id_q[cur];
                busy_q[cur]  = 1'b0;
                live_q--;
                if (live_q == 0) begin
                    serve_q = '0;
                    prior_q = '0;
                end else begin
                    ring_q[prior_q] = nxt;
                    serve_q         = nxt;
                end
            end else begin
                ticks_q[cur] = ticks_q[cur] - 1'b1;
                prior_q      = cur;
                serve_q      = nxt;
            end
        end
        r.live_tasks = CNT_W'(live_q);
        return r;
    endfunction

    task automatic note_mismatch(input string what, input sched_result_t want,
                                 input sched_result_t got);
        fails++;
        if (fails <= SHOW_LIMIT) begin
            $display("%0t mismatch (%s): expected done_valid=%0b done_id=%h rejected=%0b live=%0d",
                     $realtime, what, want.done_valid, want.done_id, want.add_rejected,
                     want.live_tasks);
            $display("%0t               got      done_valid=%0b done_id=%h rejected=%0b live=%0d",
                     $realtime, got.done_valid, got.done_id, got.add_rejected,
                     got.live_tasks);
        end
    endtask

    always @(posedge i_clk) begin
        sched_result_t want;
        sched_result_t got;
        if (!i_rst_n) begin
            busy_q  = '0;
            serve_q = '0;
            prior_q = '0;
            live_q  = 0;
            expected_q.delete();
        end else begin
            // retire the result first: it belongs to an earlier request
            if (i_rsp.valid && i_rsp.ready) begin
                got = {i_rsp.done_valid, i_rsp.done_id, i_rsp.add_rejected, i_rsp.live_tasks};
                if (expected_q.size() == 0) begin
                    note_mismatch("no request waiting", '0, got);
                end else begin
                    want = expected_q.pop_front();
                    if (got.done_valid !== want.done_valid || got.done_id !== want.done_id ||
                        got.add_rejected !== want.add_rejected ||
                        got.live_tasks !== want.live_tasks) begin
                        note_mismatch("field", want, got);
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                expected_q.push_back(schedule_step(i_req.mode, i_req.process_id,
                                                   i_req.exec_time));
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_q.size();
    end

endmodule

// ===== dv/round_robin_tick_scheduler_tb.sv =====
`timescale 1ns / 100ps
// Top of the round-robin tick scheduler testbench: clock, reset, request and
// result-side traffic, watchdog and verdict. Depends on rrts_pkg, rrts_if,
// rrts_sched_checker and the scheduler RTL.
module round_robin_tick_scheduler_tb;
    import rrts_pkg::*;

    localparam int MAX_TASKS   = 16;
    localparam int CNT_W       = 5;
    localparam int RAND_ITEMS  = 1025;
    localparam int STALL_PCT   = 21;
    localparam int WDOG_LIMIT  = 5000;
    localparam int DRAIN_WAIT  = 30;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic no_idle = 1'b0;
    int   fail_count;
    int   pending;
    int   quiet_cycles = 0;

    rrts_req_if                  req_ch ();
    rrts_rsp_if #(.CNT_W(CNT_W)) rsp_ch ();

    round_robin_tick_scheduler #(
        .MAX_TASKS(MAX_TASKS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    rrts_sched_checker #(
        .MAX_TASKS(MAX_TASKS),
        .CNT_W    (CNT_W)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .i_rsp       (rsp_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // result side stalls at random unless the quiet stretch is on
    always @(posedge i_clk) begin
        rsp_ch.ready <= i_rst_n && (no_idle || $urandom_range(99) >= STALL_PCT);
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WDOG_LIMIT);
        $display("round_robin_tick_scheduler_tb: FAIL");
        $finish;
    end

    task automatic send_request(input logic m, input logic [ID_W-1:0] pid,
                                input logic [TIME_W-1:0] et);
        while (!no_idle && $urandom_range(99) < STALL_PCT) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= m;
        req_ch.process_id <= pid;
        req_ch.exec_time  <= et;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // hold off new requests until every result is back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        logic              m;
        logic [TIME_W-1:0] et;
        int                pick;
        req_ch.valid      <= 1'b0;
        req_ch.mode       <= MODE_ADD;
        req_ch.process_id <= '0;
        req_ch.exec_time  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty tick, zero-tick task, extremes, fill to reject
        send_request(MODE_TICK, 16'hFFFF, 16'hFFFF);
        send_request(MODE_ADD, 16'h0000, 16'h0000);
        send_request(MODE_TICK, 16'h0000, 16'h0000);
        send_request(MODE_ADD, 16'hFFFF, 16'hFFFF);
        send_request(MODE_ADD, 16'h5A5A, 16'h0001);
        send_request(MODE_TICK, 16'h0000, 16'h0000);
        send_request(MODE_TICK, 16'h0000, 16'h0000);
        for (int k = 0; k < MAX_TASKS - 1; k++)
            send_request(MODE_ADD, 16'hA5A5 ^ ID_W'(k), TIME_W'(k % 4));
        send_request(MODE_ADD, 16'h1234, 16'h0003);
        send_request(MODE_TICK, 16'h0000, 16'h0000);
        send_request(MODE_TICK, 16'hFFFF, 16'hFFFF);
        wait_drained();

        // random: alternate add-heavy and tick-heavy phases to fill and empty
        for (int i = 0; i < RAND_ITEMS; i++) begin
            no_idle <= (i >= 300 && i < 450);
            if (i % 200 == 199) wait_drained();
            m = ($urandom_range(99) < (((i / 60) % 2 == 0) ? 70 : 30)) ? MODE_ADD : MODE_TICK;
            pick = $urandom_range(99);
            if (m == MODE_TICK)
                et = TIME_W'($urandom);
            else if (pick < 55)
                et = TIME_W'($urandom_range(3));
            else if (pick < 90)
                et = TIME_W'($urandom_range(24, 4));
            else
                et = TIME_W'($urandom_range(300, 25));
            send_request(m, ID_W'($urandom), et);
        end

        no_idle <= 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("round_robin_tick_scheduler_tb: PASS");
        else
            $display("round_robin_tick_scheduler_tb: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rrts_pkg.sv
rtl/core/rrts_if.sv
rtl/core/rrts_slot_scan.sv
rtl/core/rrts_table.sv
rtl/core/round_robin_tick_scheduler.sv
dv/rrts_sched_checker.sv
dv/round_robin_tick_scheduler_tb.sv
